// ===== rtl/assert_macros.svh =====
// assertion macros shared by the rtl
// no dependencies; included by the top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// next-cycle implication, checked out of reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== rtl/ddo_pkg.sv =====
// types, constants and tables of the arc odometry block
// no dependencies; used by every rtl module
package ddo_pkg;

    localparam int TAB_LEN          = 24;
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int QUEUE_DEPTH      = 2;
    localparam int DIV_NW           = 48;
    localparam int DIV_DW           = 19;

    localparam logic [29:0] CORDIC_GAIN_INV = 30'd652032874;
    localparam logic [29:0] TURN32_PER_RAD  = 30'd683565276;
    localparam logic [17:0] SPACING_RESET   = 18'd51200;

    localparam logic [29:0] ARC_TAB [TAB_LEN] = '{
        30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
        30'd21354465, 30'd10679838, 30'd5340245, 30'd2670163, 30'd1335087,
        30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41722, 30'd20861,
        30'd10430, 30'd5215, 30'd2608, 30'd1304, 30'd652, 30'd326, 30'd163, 30'd81
    };

    // register indexes
    localparam logic [2:0] REG_SPACING   = 3'd0;
    localparam logic [2:0] REG_START_X   = 3'd1;
    localparam logic [2:0] REG_START_Y   = 3'd2;
    localparam logic [2:0] REG_START_HDG = 3'd3;
    localparam logic [2:0] REG_TOLERANCE = 3'd4;

    // command codes
    localparam logic CMD_STEP   = 1'b0;
    localparam logic CMD_RELOAD = 1'b1;

    typedef struct packed {
        logic              cmd;
        logic signed [15:0] travel_left;
        logic signed [15:0] travel_right;
    } item_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic [15:0]        heading;
        logic               radius_saturated;
    } result_t;

    // classified operation passed from front to back
    typedef struct packed {
        logic               reload;
        logic               straight;
        logic               d_neg;
        logic               r_neg;
        logic signed [16:0] s;
        logic [15:0]        ad;
        logic [16:0]        as_mag;
    } op_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

    typedef struct packed {
        logic [17:0]        wheel_spacing;
        logic signed [31:0] start_x;
        logic signed [31:0] start_y;
        logic [15:0]        start_heading;
    } cfg_t;

endpackage

// ===== rtl/ddo_front.sv =====
// front end: classifies an incoming transaction into an operation
// depends on ddo_pkg
module ddo_front (
    input  ddo_pkg::item_t item,
    input  logic [7:0]     tolerance,
    output ddo_pkg::op_t   op
);
    import ddo_pkg::*;

    logic signed [16:0] d;
    logic signed [16:0] s;
    logic [16:0]        d_abs;
    logic [16:0]        s_abs;

    // wheel difference and sum
    always_comb
    begin
        d     = 17'(item.travel_right) - 17'(item.travel_left);
        s     = 17'(item.travel_right) + 17'(item.travel_left);
        d_abs = d[16] ? 17'(-d) : 17'(d);
        s_abs = s[16] ? 17'(-s) : 17'(s);
    end

    // classification
    always_comb
    begin
        op.reload   = (item.cmd == CMD_RELOAD);
        op.straight = (d_abs <= {9'd0, tolerance});
        op.d_neg    = d[16];
        op.r_neg    = s[16] != d[16];
        op.s        = s;
        op.ad       = d_abs[15:0];
        op.as_mag   = s_abs;
    end

endmodule

// ===== rtl/ddo_queue.sv =====
// short operation queue between front and back
// depends on ddo_pkg
module ddo_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  ddo_pkg::op_t         wr_op,
    input  logic                 pop,
    output ddo_pkg::op_t         rd_op,
    output ddo_pkg::q_status_t   status,
    output logic [1:0]           fill
);
    import ddo_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);

    op_t           entry_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [1:0]    count_reg;

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= wr_op;
        end
    end

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    assign rd_op        = entry_reg[rd_ptr_reg];
    assign status.empty = (count_reg == 2'd0);
    assign status.full  = (count_reg == 2'(QUEUE_DEPTH));
    assign fill         = count_reg;

endmodule

// ===== rtl/ddo_div.sv =====
// restoring divider, one quotient bit per cycle
// depends on ddo_pkg
module ddo_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [ddo_pkg::DIV_NW-1:0]     dividend,
    input  logic [ddo_pkg::DIV_DW-1:0]     divisor,
    output logic                           busy,
    output logic [ddo_pkg::DIV_NW-1:0]     quotient
);
    import ddo_pkg::*;

    localparam int CW = $clog2(DIV_NW + 1);

    logic [DIV_NW-1:0] num_reg;
    logic [DIV_DW-1:0] den_reg;
    logic [DIV_DW-1:0] rem_reg;
    logic [CW-1:0]     cnt_reg;
    logic              busy_reg;
    logic [DIV_DW:0]   trial;
    logic [DIV_DW+1:0] diff;
    logic              q_bit;
    logic [DIV_DW-1:0] rem_next;

    // one trial subtraction
    always_comb
    begin
        trial    = {rem_reg, num_reg[DIV_NW-1]};
        diff     = {1'b0, trial} - {2'b00, den_reg};
        q_bit    = !diff[DIV_DW+1];
        rem_next = q_bit ? diff[DIV_DW-1:0] : trial[DIV_DW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= dividend;
            den_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[DIV_NW-2:0], q_bit};
            rem_reg <= rem_next;
        end
    end

    // iteration control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CW'(DIV_NW - 1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    assign busy     = busy_reg;
    assign quotient = num_reg;

endmodule

// ===== rtl/ddo_cordic.sv =====
// rotation-mode cordic, one micro-rotation per cycle, q30 sine and cosine
// depends on ddo_pkg
module ddo_cordic #(
    parameter int STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [31:0]        phase,
    output logic               busy,
    output logic signed [31:0] cos_q30,
    output logic signed [31:0] sin_q30
);
    import ddo_pkg::*;

    localparam int N  = (STEPS > TAB_LEN) ? TAB_LEN : STEPS;
    localparam int CW = $clog2(TAB_LEN);

    logic signed [33:0] x_reg;
    logic signed [33:0] y_reg;
    logic signed [33:0] z_reg;
    logic               flip_reg;
    logic [CW-1:0]      cnt_reg;
    logic               busy_reg;
    logic [31:0]        phase_q;
    logic               flip;
    logic [31:0]        phase_fold;
    logic signed [33:0] dx;
    logic signed [33:0] dy;
    logic signed [33:0] ang;

    // fold into the right half plane
    always_comb
    begin
        phase_q    = phase + 32'h4000_0000;
        flip       = phase_q[31];
        phase_fold = flip ? (phase - 32'h8000_0000) : phase;
        dx         = y_reg >>> cnt_reg;
        dy         = x_reg >>> cnt_reg;
        ang        = $signed({4'b0000, ARC_TAB[cnt_reg]});
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg    <= $signed({4'b0000, CORDIC_GAIN_INV});
            y_reg    <= '0;
            z_reg    <= $signed({{2{phase_fold[31]}}, phase_fold});
            flip_reg <= flip;
        end
        else if (busy_reg)
        begin
            if (!z_reg[33])
            begin
                x_reg <= x_reg - dx;
                y_reg <= y_reg + dy;
                z_reg <= z_reg - ang;
            end
            else
            begin
                x_reg <= x_reg + dx;
                y_reg <= y_reg - dy;
                z_reg <= z_reg + ang;
            end
        end
    end

    // iteration control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CW'(N - 1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    // undo the half turn
    always_comb
    begin
        cos_q30 = flip_reg ? 32'(-x_reg) : 32'(x_reg);
        sin_q30 = flip_reg ? 32'(-y_reg) : 32'(y_reg);
    end

    assign busy = busy_reg;

endmodule

// ===== rtl/ddo_engine.sv =====
// back end: sequencer that applies one operation to the pose
// depends on ddo_pkg, ddo_cordic, ddo_div
module ddo_engine #(
    parameter int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  ddo_pkg::cfg_t    cfg,
    input  ddo_pkg::op_t     op,
    input  logic             op_avail,
    output logic             op_pop,
    output ddo_pkg::result_t result,
    output logic             result_valid,
    input  logic             result_stall
);
    import ddo_pkg::*;

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_HEAD = 5'd1;
    localparam logic [4:0] S_ST1  = 5'd2;
    localparam logic [4:0] S_ST2  = 5'd3;
    localparam logic [4:0] S_ST3  = 5'd4;
    localparam logic [4:0] S_MK1  = 5'd5;
    localparam logic [4:0] S_MK2  = 5'd6;
    localparam logic [4:0] S_DIV1 = 5'd7;
    localparam logic [4:0] S_DIV2 = 5'd8;
    localparam logic [4:0] S_M1   = 5'd9;
    localparam logic [4:0] S_M2   = 5'd10;
    localparam logic [4:0] S_M3   = 5'd11;
    localparam logic [4:0] S_M4   = 5'd12;
    localparam logic [4:0] S_M5   = 5'd13;
    localparam logic [4:0] S_M6   = 5'd14;
    localparam logic [4:0] S_M7   = 5'd15;

    logic [4:0]         state_reg;
    op_t                op_reg;
    logic signed [31:0] ch_reg;
    logic signed [31:0] sh_reg;
    logic [31:0]        phase_reg;
    logic signed [31:0] r_reg;
    logic               sat_reg;
    logic signed [33:0] fwd_reg;
    logic signed [33:0] lat_reg;
    logic signed [67:0] acc_reg;
    logic signed [67:0] prod_reg;
    logic [31:0]        pose_x_reg;
    logic [31:0]        pose_y_reg;
    logic [15:0]        pose_hdg_reg;
    result_t            out_reg;
    logic               out_valid_reg;

    logic               can_out;
    logic               out_load;
    logic [17:0]        sp;
    logic               cordic_start;
    logic [31:0]        cordic_phase;
    logic               cordic_busy;
    logic signed [31:0] cordic_cos;
    logic signed [31:0] cordic_sin;
    logic               div_start;
    logic [DIV_NW-1:0]  div_num;
    logic [DIV_DW-1:0]  div_den;
    logic               div_busy;
    logic [DIV_NW-1:0]  div_quot;
    logic signed [33:0] mul_a;
    logic signed [33:0] mul_b;
    logic               mul_en;
    logic signed [67:0] st_sum;
    logic signed [67:0] q30_sum;
    logic signed [67:0] x_sum;
    logic signed [67:0] y_sum;
    logic [31:0]        phase_c;
    logic               sat_c;
    logic [31:0]        rmag_c;
    logic [31:0]        hinc;

    ddo_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cordic_start),
        .phase   (cordic_phase),
        .busy    (cordic_busy),
        .cos_q30 (cordic_cos),
        .sin_q30 (cordic_sin)
    );

    ddo_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_num),
        .divisor  (div_den),
        .busy     (div_busy),
        .quotient (div_quot)
    );

    // output slot free or being taken
    assign can_out = !out_valid_reg || !result_stall;
    assign sp      = (cfg.wheel_spacing == 18'd0) ? 18'd1 : cfg.wheel_spacing;

    // rounding and arc helpers
    always_comb
    begin
        st_sum  = prod_reg + 68'sh4000_0000;
        q30_sum = prod_reg + 68'sh2000_0000;
        x_sum   = acc_reg - prod_reg + 68'sh2000_0000;
        y_sum   = acc_reg + prod_reg + 68'sh2000_0000;
        phase_c = op_reg.d_neg ? (32'd0 - div_quot[31:0]) : div_quot[31:0];
        sat_c   = |div_quot[DIV_NW-1:31];
        rmag_c  = sat_c ? 32'h7FFF_FFFF : div_quot[31:0];
        hinc    = phase_reg + 32'h0000_8000;
    end

    // unit launches
    always_comb
    begin
        cordic_start = 1'b0;
        cordic_phase = {pose_hdg_reg, 16'h0000};
        div_start    = 1'b0;
        div_num      = {prod_reg[46:0], 1'b0} + {30'd0, sp};
        div_den      = {sp, 1'b0};
        op_pop       = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (op_avail && (!op.reload || can_out))
                begin
                    op_pop       = 1'b1;
                    cordic_start = !op.reload;
                end
            end
            S_MK2:
            begin
                div_start = 1'b1;
            end
            S_DIV1:
            begin
                if (!div_busy)
                begin
                    cordic_start = 1'b1;
                    cordic_phase = phase_c;
                    div_start    = 1'b1;
                    div_num      = {prod_reg[46:0], 1'b0} + {31'd0, op_reg.ad, 1'b0};
                    div_den      = {1'b0, op_reg.ad, 2'b00};
                end
            end
            default:
            begin
            end
        endcase
    end

    // result register load
    always_comb
    begin
        out_load = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                out_load = op_pop && op.reload;
            end
            S_ST3, S_M7:
            begin
                out_load = can_out;
            end
            default:
            begin
            end
        endcase
    end

    // shared multiplier operands
    always_comb
    begin
        mul_en = 1'b1;
        mul_a  = '0;
        mul_b  = '0;
        unique case (state_reg)
            S_ST1:
            begin
                mul_a = {{17{op_reg.s[16]}}, op_reg.s};
                mul_b = {{2{ch_reg[31]}}, ch_reg};
            end
            S_ST2:
            begin
                mul_a = {{17{op_reg.s[16]}}, op_reg.s};
                mul_b = {{2{sh_reg[31]}}, sh_reg};
            end
            S_MK1:
            begin
                mul_a = {18'd0, op_reg.ad};
                mul_b = {4'd0, TURN32_PER_RAD};
            end
            S_MK2:
            begin
                mul_a = {16'd0, sp};
                mul_b = {17'd0, op_reg.as_mag};
            end
            S_M1:
            begin
                mul_a = {{2{r_reg[31]}}, r_reg};
                mul_b = {{2{cordic_sin[31]}}, cordic_sin};
            end
            S_M2:
            begin
                mul_a = {{2{r_reg[31]}}, r_reg};
                mul_b = 34'sh0_4000_0000 - {{2{cordic_cos[31]}}, cordic_cos};
            end
            S_M3:
            begin
                mul_a = fwd_reg;
                mul_b = {{2{ch_reg[31]}}, ch_reg};
            end
            S_M4:
            begin
                mul_a = lat_reg;
                mul_b = {{2{sh_reg[31]}}, sh_reg};
            end
            S_M5:
            begin
                mul_a = fwd_reg;
                mul_b = {{2{sh_reg[31]}}, sh_reg};
            end
            S_M6:
            begin
                mul_a = lat_reg;
                mul_b = {{2{ch_reg[31]}}, ch_reg};
            end
            default:
            begin
                mul_en = 1'b0;
            end
        endcase
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (mul_en)
        begin
            prod_reg <= mul_a * mul_b;
        end
        if (op_pop)
        begin
            op_reg <= op;
        end
        unique case (state_reg)
            S_HEAD:
            begin
                ch_reg <= cordic_cos;
                sh_reg <= cordic_sin;
            end
            S_DIV1:
            begin
                phase_reg <= phase_c;
            end
            S_DIV2:
            begin
                sat_reg <= sat_c;
                r_reg   <= op_reg.r_neg ? $signed(32'd0 - rmag_c) : $signed(rmag_c);
            end
            S_M2:
            begin
                fwd_reg <= q30_sum[63:30];
            end
            S_M3:
            begin
                lat_reg <= q30_sum[63:30];
            end
            S_M4, S_M6:
            begin
                acc_reg <= prod_reg;
            end
            default:
            begin
            end
        endcase
    end

    // sequencer, pose and result slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pose_x_reg    <= '0;
            pose_y_reg    <= '0;
            pose_hdg_reg  <= '0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (op_pop)
                    begin
                        if (op.reload)
                        begin
                            pose_x_reg    <= cfg.start_x;
                            pose_y_reg    <= cfg.start_y;
                            pose_hdg_reg  <= cfg.start_heading;
                            out_reg       <= '{cfg.start_x, cfg.start_y,
                                               cfg.start_heading, 1'b0};
                        end
                        else
                        begin
                            state_reg <= S_HEAD;
                        end
                    end
                end
                S_HEAD:
                begin
                    if (!cordic_busy)
                    begin
                        state_reg <= op_reg.straight ? S_ST1 : S_MK1;
                    end
                end
                S_ST1:
                begin
                    state_reg <= S_ST2;
                end
                S_ST2:
                begin
                    pose_x_reg <= pose_x_reg + st_sum[62:31];
                    state_reg  <= S_ST3;
                end
                S_ST3:
                begin
                    if (can_out)
                    begin
                        pose_y_reg    <= pose_y_reg + st_sum[62:31];
                        out_reg       <= '{pose_x_reg, pose_y_reg + st_sum[62:31],
                                           pose_hdg_reg, 1'b0};
                        state_reg     <= S_IDLE;
                    end
                end
                S_MK1:
                begin
                    state_reg <= S_MK2;
                end
                S_MK2:
                begin
                    state_reg <= S_DIV1;
                end
                S_DIV1:
                begin
                    if (!div_busy)
                    begin
                        state_reg <= S_DIV2;
                    end
                end
                S_DIV2:
                begin
                    if (!div_busy && !cordic_busy)
                    begin
                        state_reg <= S_M1;
                    end
                end
                S_M1:
                begin
                    state_reg <= S_M2;
                end
                S_M2:
                begin
                    state_reg <= S_M3;
                end
                S_M3:
                begin
                    state_reg <= S_M4;
                end
                S_M4:
                begin
                    state_reg <= S_M5;
                end
                S_M5:
                begin
                    pose_x_reg <= pose_x_reg + x_sum[61:30];
                    state_reg  <= S_M6;
                end
                S_M6:
                begin
                    state_reg <= S_M7;
                end
                S_M7:
                begin
                    if (can_out)
                    begin
                        pose_y_reg    <= pose_y_reg + y_sum[61:30];
                        pose_hdg_reg  <= pose_hdg_reg + hinc[31:16];
                        out_reg       <= '{pose_x_reg, pose_y_reg + y_sum[61:30],
                                           pose_hdg_reg + hinc[31:16], sat_reg};
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign result       = out_reg;
    assign result_valid = out_valid_reg;

endmodule

// ===== rtl/diff_drive_arc_odometry.sv =====
// differential drive arc odometry: register file, front, queue and engine
// depends on ddo_pkg, ddo_front, ddo_queue, ddo_engine, assert_macros.svh
//
// Usage:
// item channel (item_valid / item_stall / item) takes one transaction per
// wheel sample: cmd step with left and right travel, or cmd reload, which
// loads the start pose. Each transaction gives exactly one result on the
// result channel (result_valid / result_stall / result) with the new pose.
// Items are classified and queued in a two-entry queue; item_stall rises
// when the queue is full. The engine handles one item at a time, taking it
// from the queue while idle, and takes no new item until its result is
// loaded. A straight step is paced by the heading sine and cosine; an arc
// step by the restoring divider run twice plus the heading CORDIC; the arc
// sine and cosine overlap the second division.
// A result stays on result while result_stall is high; the engine holds its
// last step until the result register is free, and the queue keeps taking
// items until full. Reset clears the pose, the queue and the registers to
// their reset values. Registers are to be written over APB only while idle;
// the user must keep to this, as the block does not enforce it.
`include "assert_macros.svh"

module diff_drive_arc_odometry #(
    parameter int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    input  ddo_pkg::item_t   item,
    output logic             result_valid,
    input  logic             result_stall,
    output ddo_pkg::result_t result,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [4:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import ddo_pkg::*;

    cfg_t        cfg_reg;
    logic [7:0]  tol_reg;
    logic        cfg_wr;
    logic [2:0]  reg_idx;
    op_t         front_op;
    op_t         queue_op;
    q_status_t   q_status;
    logic [1:0]  q_fill;
    logic        push;
    logic        pop;

    // register file
    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.wheel_spacing <= SPACING_RESET;
            cfg_reg.start_x       <= '0;
            cfg_reg.start_y       <= '0;
            cfg_reg.start_heading <= '0;
            tol_reg               <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx)
                REG_SPACING:   cfg_reg.wheel_spacing <= pwdata[17:0];
                REG_START_X:   cfg_reg.start_x       <= pwdata;
                REG_START_Y:   cfg_reg.start_y       <= pwdata;
                REG_START_HDG: cfg_reg.start_heading <= pwdata[15:0];
                REG_TOLERANCE: tol_reg               <= pwdata[7:0];
                default:
                begin
                end
            endcase
        end
    end

    // register read
    always_comb
    begin
        unique case (reg_idx)
            REG_SPACING:   prdata = {14'd0, cfg_reg.wheel_spacing};
            REG_START_X:   prdata = cfg_reg.start_x;
            REG_START_Y:   prdata = cfg_reg.start_y;
            REG_START_HDG: prdata = {16'd0, cfg_reg.start_heading};
            REG_TOLERANCE: prdata = {24'd0, tol_reg};
            default:       prdata = '0;
        endcase
    end

    // front end and queue
    assign item_stall = q_status.full;
    assign push       = item_valid && !item_stall;

    ddo_front u_front (
        .item      (item),
        .tolerance (tol_reg),
        .op        (front_op)
    );

    ddo_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wr_op  (front_op),
        .pop    (pop),
        .rd_op  (queue_op),
        .status (q_status),
        .fill   (q_fill)
    );

    // back end
    ddo_engine #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_engine (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .op           (queue_op),
        .op_avail     (!q_status.empty),
        .op_pop       (pop),
        .result       (result),
        .result_valid (result_valid),
        .result_stall (result_stall)
    );

    // checks
    `ASSERT_IMPLIES(a_pop_not_empty, clk, rst_n, pop, !q_status.empty)
    `ASSERT_IMPLIES(a_fill_bounded, clk, rst_n, 1'b1, q_fill <= 2'(QUEUE_DEPTH))
    `ASSERT_NEXT(a_push_fills, clk, rst_n, push && !pop, q_fill == $past(q_fill) + 2'd1)

endmodule

// ===== sim/odometry_checker.sv =====
// checker for the arc odometry block: watches both channels, predicts the pose
// depends on ddo_pkg; instantiated by testbench beside the block
`timescale 1ns / 100ps

module odometry_checker (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    input  logic             item_stall,
    input  ddo_pkg::item_t   item,
    input  logic             result_valid,
    input  logic             result_stall,
    input  ddo_pkg::result_t result,
    input  logic [17:0]      cfg_spacing,
    input  logic [31:0]      cfg_start_x,
    input  logic [31:0]      cfg_start_y,
    input  logic [15:0]      cfg_start_heading,
    input  logic [7:0]       cfg_tolerance,
    output int               fail_count,
    output int               pending,
    output int               arc_count,
    output int               sat_count
);
    import ddo_pkg::*;

    localparam int STEPS = CORDIC_STEPS_DEF;

    logic [31:0] pose_x;
    logic [31:0] pose_y;
    logic [15:0] pose_heading;
    result_t     expected_poses[$];

    function automatic longint floor_shr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint round_q30(longint v);
        return (v + (64'sd1 <<< 29)) >>> 30;
    endfunction

    // rotation-mode cordic, q30 cosine and sine of a 32-bit binary angle
    task automatic sin_cos(input logic [31:0] phase, output longint c, output longint s);
        longint x, y, z, dx, dy;
        logic   flip;
        logic [31:0] p;
        x = longint'(CORDIC_GAIN_INV);
        y = 0;
        p = phase;
        flip = 1'b0;
        if (((p + 32'h4000_0000) & 32'h8000_0000) != 0) begin
            p = p - 32'h8000_0000;
            flip = 1'b1;
        end
        z = longint'(signed'(p));
        for (int i = 0; i < STEPS; i++) begin
            dx = floor_shr(y, i);
            dy = floor_shr(x, i);
            if (z >= 0) begin
                x -= dx; y += dy; z -= longint'(ARC_TAB[i]);
            end
            else begin
                x += dx; y -= dy; z += longint'(ARC_TAB[i]);
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endtask

    // advance the pose by one transaction and queue the resulting pose
    task automatic predict_pose(input item_t it);
        result_t r;
        longint lt, rt, d, sm, ad, as_v, ch, sh, sp, rq, au, rad, cd, sd, fwd, lat;
        logic [31:0] phase;
        r = '0;
        if (it.cmd == CMD_RELOAD) begin
            pose_x = cfg_start_x;
            pose_y = cfg_start_y;
            pose_heading = cfg_start_heading;
        end
        else begin
            lt = longint'(it.travel_left);
            rt = longint'(it.travel_right);
            d = rt - lt;
            sm = rt + lt;
            ad = d < 0 ? -d : d;
            as_v = sm < 0 ? -sm : sm;
            sin_cos({pose_heading, 16'h0}, ch, sh);
            if (ad <= longint'(cfg_tolerance)) begin
                pose_x += 32'(floor_shr(sm * ch + (64'sd1 <<< 30), 31));
                pose_y += 32'(floor_shr(sm * sh + (64'sd1 <<< 30), 31));
            end
            else begin
                arc_count++;
                sp = cfg_spacing == 0 ? 1 : longint'(cfg_spacing);
                rq = (2 * sp * as_v + 2 * ad) / (4 * ad);
                au = (2 * ad * longint'(TURN32_PER_RAD) + sp) / (2 * sp);
                phase = 32'(au);
                if (rq > 64'sd2147483647) begin
                    rq = 64'sd2147483647;
                    r.radius_saturated = 1'b1;
                    sat_count++;
                end
                rad = ((sm < 0) != (d < 0)) ? -rq : rq;
                if (d < 0)
                    phase = 32'd0 - phase;
                sin_cos(phase, cd, sd);
                fwd = round_q30(rad * sd);
                lat = round_q30(rad * ((64'sd1 <<< 30) - cd));
                pose_x += 32'(round_q30(fwd * ch - lat * sh));
                pose_y += 32'(round_q30(fwd * sh + lat * ch));
                pose_heading = pose_heading + 16'((phase + 32'h8000) >> 16);
            end
        end
        r.pos_x = pose_x;
        r.pos_y = pose_y;
        r.heading = pose_heading;
        expected_poses.push_back(r);
    endtask

    // watch both channels at each edge
    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n) begin
            pose_x <= '0;
            pose_y <= '0;
            pose_heading <= '0;
            fail_count = 0;
            arc_count = 0;
            sat_count = 0;
            expected_poses.delete();
        end
        else begin
            if (item_valid && !item_stall)
                predict_pose(item);
            if (result_valid && !result_stall) begin
                if (expected_poses.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result transaction %h", result);
                end
                else begin
                    want = expected_poses.pop_front();
                    if (want !== result) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("pose differs: want x=%0d y=%0d h=%0d s=%0d, got x=%0d y=%0d h=%0d s=%0d",
                                want.pos_x, want.pos_y, want.heading, want.radius_saturated,
                                result.pos_x, result.pos_y, result.heading,
                                result.radius_saturated);
                    end
                end
            end
        end
        pending = expected_poses.size();
    end

endmodule

// ===== sim/testbench.sv =====
// stimulus and verdict for the arc odometry block
// depends on ddo_pkg, diff_drive_arc_odometry and odometry_checker
`timescale 1ns / 100ps

module testbench;
    import ddo_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        item_valid;
    logic        item_stall;
    item_t       item;
    logic        result_valid;
    logic        result_stall;
    result_t     result;
    logic        psel, penable, pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    logic [17:0] cfg_spacing;
    logic [31:0] cfg_start_x;
    logic [31:0] cfg_start_y;
    logic [15:0] cfg_start_heading;
    logic [7:0]  cfg_tolerance;

    int  fail_count, pending, arc_count, sat_count;
    bit  hold_off;
    int  sent;

    diff_drive_arc_odometry dut (.*);

    odometry_checker checker_i (.*);

    initial clk = 1'b0;
    always #4 clk = ~clk;

    // overall time limit
    initial
    begin
        #20ms;
        $display("diff_drive_arc_odometry: mismatch");
        $finish;
    end

    // receiver stall, mostly short gaps, a long hold-off on request
    initial
    begin
        result_stall = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_off)
                result_stall <= 1'b1;
            else if ($urandom_range(0, 3) == 0)
                result_stall <= ($urandom_range(0, 1) == 0);
            else if ($urandom_range(0, 60) == 0)
                result_stall <= 1'b1;
            else if ($urandom_range(0, 2) == 0)
                result_stall <= 1'b0;
        end
    end

    // register write: setup then access
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(posedge clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            REG_SPACING:   cfg_spacing = val[17:0];
            REG_START_X:   cfg_start_x = val;
            REG_START_Y:   cfg_start_y = val;
            REG_START_HDG: cfg_start_heading = val[15:0];
            default:       cfg_tolerance = val[7:0];
        endcase
    endtask

    // one transaction on the item channel, optional idle gap first;
    // valid stays high afterwards until a gap or drain drops it
    task automatic send_item(input logic c, input logic [15:0] l, input logic [15:0] r,
                             input bit gaps);
        int gap;
        gap = 0;
        if (gaps)
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 200) : $urandom_range(0, 3);
        if (gap > 0) begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item <= '{cmd: c, travel_left: l, travel_right: r};
        do @(posedge clk); while (item_stall);
        sent++;
    endtask

    // stop offering items and wait until the block is idle
    task automatic drain();
        item_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    // random well-formed step with a mix of straight, arc and rotation, now and then a reload
    task automatic random_step();
        logic [15:0] l, r;
        int k;
        k = $urandom_range(0, 9);
        l = 16'($urandom);
        case (k)
            0: r = l + 16'($urandom_range(0, 255));
            1: r = -l;
            2: r = l + 16'($urandom_range(0, 3));
            3: r = 16'($urandom);
            default: begin
                l = 16'($urandom_range(0, 4000)) - 16'd2000;
                r = l + 16'($urandom_range(0, 2000)) - 16'd1000;
            end
        endcase
        send_item(($urandom_range(0, 30) == 0) ? CMD_RELOAD : CMD_STEP, l, r, 1'b1);
    endtask

    initial
    begin
        int idx;
        rst_n = 1'b0;
        item_valid = 1'b0;
        item = '0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        cfg_spacing = SPACING_RESET;
        cfg_start_x = '0; cfg_start_y = '0; cfg_start_heading = '0; cfg_tolerance = '0;
        hold_off = 1'b0;
        sent = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, straight, pure rotation, reload
        send_item(CMD_STEP, 16'h0000, 16'h0000, 1'b0);
        send_item(CMD_STEP, 16'h7fff, 16'h7fff, 1'b0);
        send_item(CMD_STEP, 16'h8000, 16'h8000, 1'b0);
        send_item(CMD_STEP, 16'h8000, 16'h7fff, 1'b0);
        send_item(CMD_STEP, 16'h7fff, 16'h8000, 1'b0);
        send_item(CMD_STEP, 16'h0100, 16'hff00, 1'b0);
        send_item(CMD_STEP, 16'h7fff, 16'h7ffe, 1'b0);
        send_item(CMD_STEP, 16'h8000, 16'h8001, 1'b0);
        send_item(CMD_STEP, 16'h1234, 16'h1334, 1'b0);
        send_item(CMD_RELOAD, 16'hffff, 16'hffff, 1'b0);
        drain();
        write_reg(REG_SPACING, 32'h3ffff);
        write_reg(REG_TOLERANCE, 32'hff);
        write_reg(REG_START_X, 32'h7fff_ffff);
        write_reg(REG_START_Y, 32'h8000_0000);
        write_reg(REG_START_HDG, 32'hffff);
        send_item(CMD_RELOAD, 16'h0, 16'h0, 1'b0);
        send_item(CMD_STEP, 16'h7fff, 16'h7fff, 1'b0);
        send_item(CMD_STEP, 16'h0000, 16'h00ff, 1'b0);
        send_item(CMD_STEP, 16'h0000, 16'h0100, 1'b0);
        send_item(CMD_STEP, 16'h7fff, 16'h7eff, 1'b0);
        drain();
        write_reg(REG_SPACING, 32'h0);
        write_reg(REG_TOLERANCE, 32'h0);
        send_item(CMD_STEP, 16'h0000, 16'h0001, 1'b0);
        send_item(CMD_STEP, 16'h7fff, 16'h8000, 1'b0);
        drain();
        write_reg(REG_START_X, 32'h0);

        // long receiver hold-off so the queue fills and stalls the input
        drain();
        hold_off = 1'b1;
        fork
            begin
                repeat (1500) @(posedge clk);
                hold_off = 1'b0;
            end
            begin
                repeat (6) random_step();
                drain();
            end
        join

        // random phases with varied settings
        for (int phase_no = 0; phase_no < 8; phase_no++) begin
            drain();
            write_reg(REG_SPACING, (phase_no == 0) ? 32'd1 : $urandom_range(1, 262143));
            write_reg(REG_TOLERANCE, (phase_no == 1) ? 32'd255 : $urandom_range(0, 255));
            write_reg(REG_START_X, $urandom);
            write_reg(REG_START_Y, $urandom);
            write_reg(REG_START_HDG, $urandom);
            repeat (50) random_step();
        end

        drain();
        $display("sent %0d transactions, %0d arc steps, %0d clamped radii",
            sent, arc_count, sat_count);
        if (fail_count == 0)
            $display("diff_drive_arc_odometry: match");
        else
            $display("diff_drive_arc_odometry: mismatch");
        $finish;
    end

endmodule
